// ----- rtl/core/b64e_pkg.sv -----
// shared types, constants and the character lookup for the base64 encoder
package b64e_pkg;

  // depth of the group queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // ascii pad character '='
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // index of the final character of a four-character group
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // group position codes
  localparam logic [1:0] POS_EMPTY = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;

  // one completed or flushed three-byte group
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pad_cnt;
    logic        last;
  } grp_t;

  // push side of the queue
  typedef struct packed {
    logic valid;
    grp_t entry;
  } q_push_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // front status, visible for checking
  typedef struct packed {
    logic [1:0] pos;
  } f_stat_t;

  // map a 6-bit index to its standard-alphabet ascii code
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] wide;
    wide = {1'b0, idx};
    if (idx < 6'd26) begin
      return wide + 7'd65;
    end else if (idx < 6'd52) begin
      return wide + 7'd71;
    end else if (idx < 6'd62) begin
      return wide - 7'd4;
    end else if (idx == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

// ----- rtl/core/b64e_byte_if.sv -----
// input byte channel: one message byte per beat
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/b64e_char_if.sv -----
// output character channel: one encoded character per beat
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/core/b64e_front.sv -----
// front end: gathers bytes into groups and pushes complete or final groups
module b64e_front import b64e_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  b64e_byte_if.sink       in_if,
  input  q_stat_t         q_stat,
  output q_push_t         q_push,
  output f_stat_t         f_stat
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        take;
  logic        emit;
  grp_t        entry;

  // accept a beat whenever the queue has room
  assign in_if.ready = !q_stat.full;
  assign take        = in_if.valid && in_if.ready;
  assign emit        = (pos_r >= POS_TWO) || in_if.last_byte;

  // build the group entry and next gather state
  always_comb begin
    entry    = '0;
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    entry.last = in_if.last_byte;
    if (pos_r >= POS_TWO) begin
      entry.bits    = {pend_r, in_if.data_byte};
      entry.pad_cnt = 2'd0;
    end else if (pos_r == POS_ONE) begin
      entry.bits    = {pend_r[15:8], in_if.data_byte, 8'h00};
      entry.pad_cnt = 2'd1;
    end else begin
      entry.bits    = {in_if.data_byte, 16'h0000};
      entry.pad_cnt = 2'd2;
    end
    if (take) begin
      if (emit) begin
        pend_nxt = '0;
        pos_nxt  = POS_EMPTY;
      end else if (pos_r == POS_EMPTY) begin
        pend_nxt = {in_if.data_byte, 8'h00};
        pos_nxt  = POS_ONE;
      end else begin
        pend_nxt = {pend_r[15:8], in_if.data_byte};
        pos_nxt  = POS_TWO;
      end
    end
  end

  assign q_push.valid = take && emit;
  assign q_push.entry = entry;
  assign f_stat.pos   = pos_r;

  // gather state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pos_r  <= POS_EMPTY;
    end else begin
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ----- rtl/core/b64e_queue.sv -----
// short group queue between front and back
module b64e_queue import b64e_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    pop,
  output grp_t    head,
  output q_stat_t q_stat
);

  grp_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = q_push.valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  // pointer advance with wrap at the queue depth
  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/b64e_back.sv -----
// back end: turns each queued group into four characters, one per beat
module b64e_back import b64e_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  grp_t          head,
  input  q_stat_t       q_stat,
  output logic          pop,
  b64e_char_if.source   out_if
);

  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       last_char_r;
  logic [1:0] slot_r;
  logic       load;
  logic       fire;
  logic [5:0] sextet;
  logic [6:0] chr;
  logic [2:0] data_cnt;

  // output register frees when empty or taken this cycle
  assign load = !out_valid_r || out_if.ready;
  assign fire = load && !q_stat.empty;
  assign pop  = fire && (slot_r == LAST_SLOT);

  // pick the sextet for the current slot, most significant first
  always_comb begin
    unique case (slot_r)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
    data_cnt = 3'd4 - {1'b0, head.pad_cnt};
    chr      = ({1'b0, slot_r} < data_cnt) ? b64_char(sextet) : PAD_CHAR;
  end

  // output register and slot counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      out_char_r  <= '0;
      last_char_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
      out_char_r  <= chr;
      last_char_r <= head.last && (slot_r == LAST_SLOT);
      slot_r      <= slot_r + 1'b1;
    end else if (load) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_char  = out_char_r;
  assign out_if.last_char = last_char_r;

endmodule

// ----- rtl/core/base64_encoder.sv -----
// base64 encoder top level: front, group queue and character back end
//
// usage
//   in_if takes one message byte per beat with last_byte on the final byte.
//   out_if gives one ascii character per beat (standard alphabet or '='),
//   last_char on the final character of the message.
//   every third byte, and every final byte, yields exactly four characters.
// group path
//   the first character of a group passes through the group queue and the
//   output register after the beat that completes or ends the group; the
//   other three follow on consecutive cycles while the receiver is ready.
// throughput
//   the back end sends one character per cycle while the receiver is ready;
//   the input takes one beat per cycle while the two-entry group queue has
//   room.
// reset
//   rst_n clears the group position, the queue and the output register;
//   the first byte after reset starts a new message.
// stalls
//   holding out_if.ready low freezes the output register, the queue fills,
//   then in_if.ready drops until a group is drained.
module base64_encoder import b64e_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  b64e_byte_if.sink     in_if,
  b64e_char_if.source   out_if
);

  q_push_t q_push;
  q_stat_t q_stat;
  f_stat_t f_stat;
  grp_t    head;
  logic    pop;

  // byte gathering
  b64e_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .q_push (q_push),
    .f_stat (f_stat)
  );

  // group queue
  b64e_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // character output
  b64e_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

  // queue status is never full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // a final byte beat always leaves a group in the queue
  a_last_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.last_byte) |=> !q_stat.empty)
    else $error("final byte did not queue a group");

  // a final byte beat returns the front to the start of a group
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.last_byte) |=> (f_stat.pos == POS_EMPTY))
    else $error("group position not cleared after final byte");

  // the front never holds three bytes
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_stat.pos != LAST_SLOT)
    else $error("group position out of range");

endmodule
